// File: rtl/string_to_char16_decoder_assert.svh
// ----------------------------------------------------------------------------
// string_to_char16_decoder assertion macros
// concurrent checks sampled on the rising clock edge, muted during reset
// ----------------------------------------------------------------------------
`ifndef STRING_TO_CHAR16_DECODER_ASSERT_SVH
`define STRING_TO_CHAR16_DECODER_ASSERT_SVH

// same-cycle implication
`define S2C_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define S2C_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/s2c16_pkg.sv
// ----------------------------------------------------------------------------
// s2c16_pkg
// shared types and codes of the escape-coded string to 16-bit char decoder
// ----------------------------------------------------------------------------
`default_nettype none

package s2c16_pkg;

  // special byte codes
  localparam logic [7:0] SubCode    = 8'h1A;
  localparam logic [7:0] SoCode     = 8'h0E;
  localparam logic [7:0] SiCode     = 8'h0F;
  localparam logic [7:0] EscCode    = 8'hFF;
  localparam logic [7:0] AtCode     = 8'h40;
  localparam logic [7:0] SlashCode  = 8'h2F;
  localparam logic [7:0] SpaceCode  = 8'h20;
  localparam logic [7:0] DelCode    = 8'h7F;
  localparam logic [7:0] HighBit    = 8'h80;
  localparam logic [7:0] PrivateSet = 8'h20;

  // queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEVEN_BIT   = 1'b0,
    CFG_PRIVATE_SET = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic seven_bit_format;
    logic start_in_private_set;
  } cfg_t;

  // one decoded byte: optional SUB char first, then optional char
  typedef struct packed {
    logic        emit_sub;
    logic        emit_char;
    logic [15:0] code_word;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/s2c16_front.sv
// ----------------------------------------------------------------------------
// s2c16_front
// accepts raw bytes, tracks escape/shift/stringlet state, queues results
// ----------------------------------------------------------------------------
`default_nettype none

module s2c16_front import s2c16_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire queue_status_t q_status,
  output logic               push,
  output queue_entry_t       push_entry
);

  logic       fresh, fresh_next;
  logic [7:0] current_set, current_set_next;
  logic       shift_out_active, shift_out_active_next;
  logic       sub_pending, sub_pending_next;
  logic       escape_seen, escape_seen_next;
  logic       expect_set_byte, expect_set_byte_next;
  logic       two_byte_mode, two_byte_mode_next;

  logic       accept;
  logic [7:0] set_eff;
  logic [7:0] ch;
  logic       consumed;
  logic       emit_sub;
  logic       emit_char;
  logic [15:0] code_word;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // decode of one byte
  always_comb begin
    set_eff               = (fresh && cfg.start_in_private_set) ? PrivateSet : current_set;
    fresh_next            = 1'b0;
    current_set_next      = set_eff;
    shift_out_active_next = shift_out_active;
    sub_pending_next      = 1'b0;
    escape_seen_next      = escape_seen;
    expect_set_byte_next  = expect_set_byte;
    two_byte_mode_next    = two_byte_mode;
    ch                    = in_byte;
    consumed              = 1'b0;
    emit_sub              = 1'b0;
    emit_char             = 1'b0;
    code_word             = {set_eff, in_byte};

    // resolve a pending SUB
    if (sub_pending) begin
      if (in_byte == AtCode) begin
        ch = 8'h00;
      end else if (in_byte == SlashCode) begin
        ch = EscCode;
      end else begin
        emit_sub = 1'b1;
      end
    end

    // shift-out and seven-bit controls
    priority if (shift_out_active && ch > SpaceCode && ch < DelCode) begin
      ch = ch | HighBit;
    end else if (cfg.seven_bit_format) begin
      priority if (ch == SubCode) begin
        sub_pending_next = 1'b1;
        consumed         = 1'b1;
      end else if (ch == SoCode) begin
        shift_out_active_next = 1'b1;
        consumed              = 1'b1;
      end else if (ch == SiCode) begin
        shift_out_active_next = 1'b0;
        consumed              = 1'b1;
      end else begin
      end
    end else begin
    end

    // escape, stringlet and plain characters
    if (!consumed) begin
      priority if (escape_seen) begin
        if (expect_set_byte) begin
          expect_set_byte_next = 1'b0;
          if (ch != EscCode) begin
            current_set_next   = ch;
            escape_seen_next   = 1'b0;
            two_byte_mode_next = 1'b0;
          end
        end else begin
          escape_seen_next     = 1'b0;
          two_byte_mode_next   = 1'b1;
          expect_set_byte_next = 1'b1;
        end
      end else if (ch == EscCode) begin
        escape_seen_next     = 1'b1;
        expect_set_byte_next = 1'b1;
      end else if (two_byte_mode) begin
        if (expect_set_byte) begin
          current_set_next     = ch;
          expect_set_byte_next = 1'b0;
        end else begin
          expect_set_byte_next = 1'b1;
          emit_char            = 1'b1;
          code_word            = {set_eff, ch};
        end
      end else if (ch <= SpaceCode) begin
        emit_char = 1'b1;
        code_word = {8'h00, ch};
      end else begin
        emit_char = 1'b1;
        code_word = {set_eff, ch};
      end
    end
  end

  assign push                 = accept && (emit_sub || emit_char);
  assign push_entry.emit_sub  = emit_sub;
  assign push_entry.emit_char = emit_char;
  assign push_entry.code_word = code_word;

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh            <= 1'b1;
      current_set      <= 8'h00;
      shift_out_active <= 1'b0;
      sub_pending      <= 1'b0;
      escape_seen      <= 1'b0;
      expect_set_byte  <= 1'b0;
      two_byte_mode    <= 1'b0;
    end else if (accept) begin
      fresh            <= fresh_next;
      current_set      <= current_set_next;
      shift_out_active <= shift_out_active_next;
      sub_pending      <= sub_pending_next;
      escape_seen      <= escape_seen_next;
      expect_set_byte  <= expect_set_byte_next;
      two_byte_mode    <= two_byte_mode_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/s2c16_queue.sv
// ----------------------------------------------------------------------------
// s2c16_queue
// short register queue of decoded entries between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module s2c16_queue import s2c16_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire queue_entry_t  push_entry,
  input  wire logic          pop,
  output queue_entry_t       head,
  output queue_status_t      status
);

  queue_entry_t               entries [QueueDepth];
  logic [QueuePtrW-1:0]       wr_ptr;
  logic [QueuePtrW-1:0]       rd_ptr;
  logic [QueueCntW-1:0]       count;

  assign status.full  = (count == QueueCntW'(QueueDepth));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/s2c16_back.sv
// ----------------------------------------------------------------------------
// s2c16_back
// expands queued entries into one or two output chars, registered output
// ----------------------------------------------------------------------------
`default_nettype none
`include "string_to_char16_decoder_assert.svh"

module s2c16_back import s2c16_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire queue_entry_t  head,
  input  wire queue_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        out_char,
  output logic               out_last
);

  logic        hold_valid;
  logic [15:0] hold_char;
  logic        load;

  // output register free or being drained
  assign load = !out_valid || out_ready;
  assign pop  = load && !hold_valid && !q_status.empty;

  // output control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (load) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (!q_status.empty) begin
        out_valid  <= 1'b1;
        hold_valid <= head.emit_sub && head.emit_char;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_valid) begin
        out_char <= hold_char;
        out_last <= 1'b1;
      end else if (head.emit_sub) begin
        out_char  <= {8'h00, SubCode};
        out_last  <= !head.emit_char;
        hold_char <= head.code_word;
      end else begin
        out_char <= head.code_word;
        out_last <= 1'b1;
      end
    end
  end

  // a held char always sits behind a shown SUB that is not last
  `S2C_ASSERT_IMP(a_hold_behind_sub, clk, rst, hold_valid,
    out_valid && !out_last && out_char == {8'h00, SubCode}, "held char without SUB in front")
  // no entry is taken while a held char waits or the output is blocked
  `S2C_ASSERT_IMP(a_pop_gated, clk, rst, pop,
    (!out_valid || out_ready) && !hold_valid, "queue popped while output busy")
  // draining the SUB brings the held char next, marked last
  `S2C_ASSERT_NXT(a_hold_follows, clk, rst, out_valid && out_ready && hold_valid,
    out_valid && out_last && !hold_valid, "held char not shown after SUB")
  // a last result never leaves a held char behind
  `S2C_ASSERT_IMP(a_last_clears_hold, clk, rst, out_valid && out_last, !hold_valid,
    "last result with char still held")

endmodule

`default_nettype wire

// File: rtl/string_to_char16_decoder.sv
// ----------------------------------------------------------------------------
// string_to_char16_decoder
// escape-coded byte string to 16-bit {set, code} characters
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  s_axis   | in        | s_axis_tvalid/tready   | tdata[7:0] in_byte
//  m_axis   | out       | m_axis_tvalid/tready   | tdata[15:0] out_char, tlast last
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
//  one byte is accepted per cycle while the queue is not full; the front decodes it in that same cycle
//  a result is written to a queue entry and then to the output register before it is presented on m_axis
//  a byte with two results (SUB then another byte) holds the output for both
//  results; the 4-entry queue absorbs this, so input stalls only when full
//  rst is synchronous; it clears configuration and decoder state to zero and
//  marks the next byte as the first one for the start-set choice
//  bytes that give no result (escape, set, SO/SI) produce no item
// ----------------------------------------------------------------------------
`default_nettype none

module string_to_char16_decoder import s2c16_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] out_char
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic        cfg_data
);

  cfg_t          cfg;
  logic          push;
  logic          pop;
  queue_entry_t  push_entry;
  queue_entry_t  head;
  queue_status_t q_status;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEVEN_BIT:   cfg.seven_bit_format     <= cfg_data;
        CFG_PRIVATE_SET: cfg.start_in_private_set <= cfg_data;
        default:         cfg <= cfg;
      endcase
    end
  end

  s2c16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  s2c16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  s2c16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: sim/string_to_char16_decoder_tb.sv
// ----------------------------------------------------------------------------
// string_to_char16_decoder_tb
// drives escape-coded byte strings into the decoder and checks every 16-bit
// character against a behavioral decoder kept inside the bench; covers set
// escapes, stringlet mode, shift-out, SUB escapes and both format settings
// under random stalls on both streams
// ----------------------------------------------------------------------------
module string_to_char16_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import s2c16_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 45;

  typedef struct {
    logic [15:0] code;
    logic        last;
  } char_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] out_char
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic        cfg_data;

  // decoder state mirrored in the bench
  logic [7:0] cur_set;
  logic       shift_out;
  logic       sub_held;
  logic       esc_seen;
  logic       want_set;
  logic       stringlet;
  logic       fresh;
  logic       fmt_seven;
  logic       fmt_private;

  char_result_t pending_chars[$];
  int unsigned  mismatch_count;
  int unsigned  idle_cycles;
  logic         tx_gaps;
  logic         rx_steady;

  string_to_char16_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // decode one accepted byte and queue the characters it yields
  function automatic void decode_byte(input logic [7:0] raw);
    logic [7:0]  c;
    logic        done;
    logic [15:0] chars[$];
    c = raw;
    done = 1'b0;
    if (fresh) begin
      fresh = 1'b0;
      if (fmt_private) cur_set = PrivateSet;
    end
    // resolve a held SUB first
    if (sub_held) begin
      sub_held = 1'b0;
      if (c == AtCode) c = 8'h00;
      else if (c == SlashCode) c = EscCode;
      else chars.push_back({8'h00, SubCode});
    end
    // shift-out or seven-bit controls
    if (shift_out && c > SpaceCode && c < DelCode) begin
      c = c | HighBit;
    end else if (fmt_seven) begin
      if (c == SubCode) begin
        sub_held = 1'b1;
        done = 1'b1;
      end else if (c == SoCode) begin
        shift_out = 1'b1;
        done = 1'b1;
      end else if (c == SiCode) begin
        shift_out = 1'b0;
        done = 1'b1;
      end
    end
    // escape, stringlet and plain bytes
    if (!done) begin
      if (esc_seen) begin
        if (want_set) begin
          want_set = 1'b0;
          if (c != EscCode) begin
            cur_set = c;
            esc_seen = 1'b0;
            stringlet = 1'b0;
          end
        end else begin
          esc_seen = 1'b0;
          stringlet = 1'b1;
          want_set = 1'b1;
        end
      end else if (c == EscCode) begin
        esc_seen = 1'b1;
        want_set = 1'b1;
      end else if (stringlet) begin
        if (want_set) begin
          cur_set = c;
          want_set = 1'b0;
        end else begin
          want_set = 1'b1;
          chars.push_back({cur_set, c});
        end
      end else if (c <= SpaceCode) begin
        chars.push_back({8'h00, c});
      end else begin
        chars.push_back({cur_set, c});
      end
    end
    foreach (chars[i]) pending_chars.push_back('{chars[i], i == chars.size() - 1});
  endfunction

  // send one byte, leaving tvalid high for a following item
  task automatic push_byte(input logic [7:0] b);
    while (tx_gaps && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    decode_byte(b);
    @(negedge clk);
  endtask

  // write one configuration register
  task automatic write_cfg(input cfg_index_t idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SEVEN_BIT:   fmt_seven = val;
      CFG_PRIVATE_SET: fmt_private = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // stop sending and wait for every queued character plus pipeline slack
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // private start set, seven-bit format off, bytes 0x41, 0x00, 0x7F and 0x80
  task automatic test_private_start;
    write_cfg(CFG_PRIVATE_SET, 1'b1);
    write_cfg(CFG_SEVEN_BIT, 1'b0);
    cfg_valid <= 1'b0;
    push_byte(8'h41);
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h80);
  endtask

  // set change, doubled escape into stringlet mode and back out
  task automatic test_set_escapes;
    push_byte(EscCode);
    push_byte(8'h05);
    push_byte(8'h42);
    push_byte(EscCode);
    push_byte(EscCode);
    push_byte(8'h99);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(EscCode);
    push_byte(8'h00);
    push_byte(SpaceCode);
  endtask

  // shift-out, SI and SUB escapes in seven-bit format
  task automatic test_seven_bit_escapes;
    drain();
    write_cfg(CFG_SEVEN_BIT, 1'b1);
    write_cfg(CFG_PRIVATE_SET, 1'b0);
    cfg_valid <= 1'b0;
    push_byte(SoCode);
    push_byte(8'h61);
    push_byte(SiCode);
    push_byte(8'h61);
    push_byte(SubCode);
    push_byte(AtCode);
    // substituted escape then a set byte
    push_byte(SubCode);
    push_byte(SlashCode);
    push_byte(8'h07);
    push_byte(8'h63);
    // SUB followed by an ordinary byte, then by another SUB
    push_byte(SubCode);
    push_byte(8'h7A);
    push_byte(SubCode);
    push_byte(SubCode);
    push_byte(AtCode);
  endtask

  // format switched off while a SUB is held
  task automatic test_format_cleared_under_sub;
    push_byte(SubCode);
    drain();
    write_cfg(CFG_SEVEN_BIT, 1'b0);
    cfg_valid <= 1'b0;
    push_byte(AtCode);
    push_byte(SubCode);
  endtask

  // random well-formed strings with some noise, several format settings
  task automatic test_random_streams;
    int unsigned sent;
    int unsigned kind;
    int unsigned reps;
    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      write_cfg(CFG_SEVEN_BIT, (p < 2) ? p[0] : 1'($urandom_range(1)));
      write_cfg(CFG_PRIVATE_SET, 1'($urandom_range(1)));
      cfg_valid <= 1'b0;
      tx_gaps = (p != 3);
      rx_steady = (p == 3);
      sent = 0;
      while (sent < PhaseItems) begin
        kind = $urandom_range(99);
        if (kind < 30) begin
          // plain text
          reps = $urandom_range(6, 1);
          repeat (reps) push_byte(8'($urandom_range(8'h7E)));
          sent += reps;
        end else if (kind < 42) begin
          // set change
          push_byte(EscCode);
          push_byte(8'($urandom_range(8'hFE)));
          sent += 2;
        end else if (kind < 52) begin
          // stringlet with a few pairs, then back to single bytes
          push_byte(EscCode);
          push_byte(EscCode);
          push_byte(8'($urandom_range(8'hFF)));
          reps = $urandom_range(4, 1);
          repeat (reps) begin
            push_byte(8'($urandom_range(8'hFE)));
            push_byte(8'($urandom_range(8'hFE)));
          end
          push_byte(EscCode);
          push_byte(8'($urandom_range(8'hFE)));
          sent += 5 + 2 * reps;
        end else if (kind < 64) begin
          // shifted-out printable run
          push_byte(SoCode);
          reps = $urandom_range(5, 1);
          repeat (reps) push_byte(8'($urandom_range(8'h7E, 8'h21)));
          push_byte(SiCode);
          sent += reps + 2;
        end else if (kind < 78) begin
          // SUB escape
          push_byte(SubCode);
          case ($urandom_range(2))
            0: push_byte(AtCode);
            1: push_byte(SlashCode);
            default: push_byte(8'($urandom_range(8'hFF)));
          endcase
          sent += 2;
        end else begin
          // noise
          reps = $urandom_range(4, 1);
          repeat (reps) push_byte(8'($urandom_range(8'hFF)));
          sent += reps;
        end
      end
    end
    tx_gaps = 1'b1;
    rx_steady = 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= rx_steady || ($urandom_range(99) >= 19);
  end

  // compare each output item with the oldest queued character
  always @(posedge clk) begin
    char_result_t exp_char;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char %h last %b", $time, m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        exp_char = pending_chars.pop_front();
        if (m_axis_tdata !== exp_char.code) begin
          $display("%0t: char expected %h actual %h", $time, exp_char.code, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tlast !== exp_char.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_char.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SEVEN_BIT;
    cfg_data = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    tx_gaps = 1'b1;
    rx_steady = 1'b0;
    cur_set = 8'h00;
    shift_out = 1'b0;
    sub_held = 1'b0;
    esc_seen = 1'b0;
    want_set = 1'b0;
    stringlet = 1'b0;
    fresh = 1'b1;
    fmt_seven = 1'b0;
    fmt_private = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_private_start();
    test_set_escapes();
    test_seven_bit_escapes();
    test_format_cleared_under_sub();
    test_random_streams();
    drain();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
